/* hdl/ordered_list_engine_assert.svh */
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ole_pkg.sv */
package ole_pkg;

  localparam int CNT_W     = 5;
  localparam int WORD_W    = 32;
  localparam int DEPTH_DEF = 16;

  localparam logic [CNT_W-1:0]  LIMIT_RST = 5'd16;
  localparam logic [WORD_W-1:0] MISS_WORD = 32'hFFFE_7961;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_GET    = 2'd2,
    REQ_LOCATE = 2'd3
  } req_t;

  typedef struct packed {
    req_t               req_type;
    logic [CNT_W-1:0]   position;
    logic signed [31:0] value;
  } ole_in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [CNT_W-1:0]   found_position;
    logic [CNT_W-1:0]   list_length;
    logic               is_empty;
    logic               is_full;
  } ole_out_t;

  typedef struct packed {
    logic              load;
    logic              ins;
    logic              del;
    logic              hit_pos;
    logic              loc;
    logic [CNT_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  cnt;
    logic [WORD_W-1:0] value;
  } ole_cmd_t;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  idx;
  } ole_col_t;

endpackage

/* hdl/ole_cell.sv */
module ole_cell
  import ole_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ole_cmd_t          cmd,
  input  logic [WORD_W-1:0] below,
  input  logic [WORD_W-1:0] above,
  input  ole_col_t          col_in,
  output logic [WORD_W-1:0] word,
  output ole_col_t          col
);

  localparam int IW = ($clog2(DEPTH + 1) > CNT_W) ? $clog2(DEPTH + 1) : CNT_W;
  localparam logic [IW-1:0] ME  = IW'(IDX);
  localparam logic [IW-1:0] ME1 = IW'(IDX + 1);

  logic [IW-1:0]     pm;
  logic [IW-1:0]     cn;
  logic [WORD_W-1:0] word_r, word_nxt;
  ole_col_t          col_r, col_nxt;

  assign pm = IW'(cmd.pos_m1);
  assign cn = IW'(cmd.cnt);

  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (ME == pm) begin
        word_nxt = cmd.value;
      end else if (ME > pm && ME <= cn) begin
        word_nxt = below;
      end
    end else if (cmd.del && ME >= pm && ME1 < cn) begin
      word_nxt = above;
    end
  end

  always_comb begin
    col_nxt = col_r;
    if (cmd.load) begin
      col_nxt.vld  = (cmd.hit_pos && ME == pm) ||
                     (cmd.loc && ME < cn && word_r == cmd.value);
      col_nxt.word = word_r;
      col_nxt.idx  = CNT_W'(IDX + 1);
    end else if (!col_r.vld) begin
      col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r.vld <= 1'b0;
    end else begin
      col_r <= col_nxt;
    end
  end

  assign word = word_r;
  assign col  = col_r;

endmodule

/* hdl/ordered_list_engine.sv */
// channel  | ports                       | beat
// ---------+-----------------------------+-------------------------------------
// request  | in_valid, in_stall, in_data | req_type, position, value
// result   | out_valid, out_stall, out_data | ok, read_value, found_position,
//          |                             |   list_length, is_empty, is_full
// config   | cfg_we, cfg_wdata           | capacity_limit
//
// For a request, all cells shift and compare at the accept edge; then
// the hit travels down the cell chain to cell 0, one cell a cycle.
// Synchronous reset clears the length, the limit (to 16) and the handshakes.
// A stalled result is held in the output register; the next request may be
// accepted meanwhile, and its result waits until that register is free.
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  ole_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ole_out_t         out_data
);

  localparam int SW = $clog2(DEPTH);
  localparam logic [CNT_W:0]  DMAX     = (CNT_W + 1)'(DEPTH < 31 ? DEPTH : 31);
  localparam logic [SW-1:0]   SWP_LAST = SW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } ole_st_t;

  typedef struct packed {
    req_t             req;
    logic             ok;
    logic [CNT_W-1:0] cnt;
    logic             full;
  } ole_pend_t;

  ole_st_t          st_r, st_nxt;
  logic [SW-1:0]    swp_r, swp_nxt;
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] eff;
  ole_pend_t        pend_r, pend_nxt;
  logic             out_valid_r;
  ole_out_t         out_r, out_nxt;

  logic             accept;
  logic             out_load;
  logic             pos_nz;
  logic             pos_ok;
  logic             ins_ok;
  logic             del_ok;
  logic             rd_ok;
  ole_cmd_t         cmd;
  ole_col_t         head;

  logic [WORD_W-1:0] word_w [DEPTH];
  ole_col_t          col_w  [DEPTH+1];

  assign eff = ({1'b0, cap_r} > DMAX) ? DMAX[CNT_W-1:0] : cap_r;

  assign in_stall = (st_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  assign pos_nz = (in_data.position != '0);
  assign pos_ok = pos_nz && (in_data.position <= cnt_r);
  assign ins_ok = (in_data.req_type == REQ_INSERT) && pos_nz &&
                  ({1'b0, in_data.position} <= ({1'b0, cnt_r} + 1'b1)) &&
                  (cnt_r < eff);
  assign del_ok = (in_data.req_type == REQ_DELETE) && pos_ok;
  assign rd_ok  = ((in_data.req_type == REQ_DELETE) ||
                   (in_data.req_type == REQ_GET)) && pos_ok;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && ins_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (accept && del_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    cmd.load    = accept;
    cmd.ins     = accept && ins_ok;
    cmd.del     = accept && del_ok;
    cmd.hit_pos = accept && rd_ok;
    cmd.loc     = accept && (in_data.req_type == REQ_LOCATE);
    cmd.pos_m1  = in_data.position - 1'b1;
    cmd.cnt     = cnt_r;
    cmd.value   = in_data.value;
  end

  assign col_w[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ole_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .below  ((i == 0) ? '0 : word_w[(i == 0) ? 0 : i - 1]),
      .above  ((i == DEPTH - 1) ? '0 : word_w[(i == DEPTH - 1) ? i : i + 1]),
      .col_in (col_w[i+1]),
      .word   (word_w[i]),
      .col    (col_w[i])
    );
  end

  assign head = col_w[0];

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt.req  = in_data.req_type;
      pend_nxt.ok   = ins_ok || rd_ok;
      pend_nxt.cnt  = cnt_nxt;
      pend_nxt.full = (cnt_nxt >= eff);
    end
  end

  assign out_load = (st_r == ST_SWEEP) && (swp_r == '0) && (!out_valid_r || !out_stall);

  always_comb begin
    st_nxt  = st_r;
    swp_nxt = swp_r;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          st_nxt  = ST_SWEEP;
          swp_nxt = SWP_LAST;
        end
      end
      ST_SWEEP: begin
        if (swp_r != '0) begin
          swp_nxt = swp_r - 1'b1;
        end else if (out_load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_nxt                = '0;
    out_nxt.list_length    = pend_r.cnt;
    out_nxt.is_empty       = (pend_r.cnt == '0);
    out_nxt.is_full        = pend_r.full;
    case (pend_r.req)
      REQ_INSERT: begin
        out_nxt.ok = pend_r.ok;
      end
      REQ_DELETE: begin
        out_nxt.ok         = pend_r.ok;
        out_nxt.read_value = head.vld ? head.word : '0;
      end
      REQ_GET: begin
        out_nxt.ok         = pend_r.ok;
        out_nxt.read_value = head.vld ? head.word : MISS_WORD;
      end
      REQ_LOCATE: begin
        out_nxt.ok             = head.vld;
        out_nxt.found_position = head.vld ? head.idx : '0;
      end
      default: begin
        out_nxt.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      swp_r       <= '0;
      cap_r       <= LIMIT_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      swp_r <= swp_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/ole_chk.sv */
`include "ordered_list_engine_assert.svh"

module ole_chk
  import ole_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input ole_out_t out_data
);

  `OLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
  `OLE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request accepted while a request is in flight")
  `OLE_ASSERT_NOW(a_empty_flag, out_valid, out_data.is_empty == (out_data.list_length == '0), "empty flag disagrees with length")
  `OLE_ASSERT_NOW(a_found_in_range, out_valid, out_data.found_position <= out_data.list_length, "found position beyond list length")

endmodule

bind ordered_list_engine ole_chk u_ole_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
